>>> design/ubds_pkg.sv
package ubds_pkg;

   localparam int DIV_W = 44;
   localparam int DVR_W = 32;
   localparam int LEN_W = 6;

   localparam logic [LEN_W-1:0] LEN_CLOCK = 6'd32;
   localparam logic [LEN_W-1:0] LEN_FRAC  = 6'd36;
   localparam logic [LEN_W-1:0] LEN_SYNTH = 6'd44;

   localparam logic [31:0] RESET_CLOCK    = 32'd48000000;
   localparam logic [31:0] FALLBACK_CLOCK = 32'd115200;
   localparam logic [31:0] SYNTH_DEFAULT  = 32'h0001ffff;
   localparam logic [7:0]  FRAC_DEFAULT   = 8'h10;

   localparam logic [1:0] MODE_PLAIN = 2'd0;
   localparam logic [1:0] MODE_FRAC  = 2'd1;
   localparam logic [1:0] MODE_SYNTH = 2'd2;

   localparam logic [1:0] CSR_CLOCK = 2'd0;
   localparam logic [1:0] CSR_MODE  = 2'd1;

   typedef struct packed {
      logic             start;
      logic [LEN_W-1:0] len;
   } div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

endpackage

>>> design/uart_baud_divisor_search_core.sv
// channel   ports                               role
// req       req_valid/req_ready, baud_rate      requested baud rate in
// rsp       rsp_valid/rsp_ready, 4 fields       divisor settings out
// csr       csr_valid/csr_ready, index, data    clock and mode registers
//
// One shared restoring divider does every division, one quotient bit per cycle.
// Plain mode: one 32-bit division. Fractional mode: two 32-bit divisions plus
// 120 candidates of a 36-bit division and one compare. Synthesizer mode:
// plain division plus 16 candidates of two 44-bit divisions. req_ready is
// low from acceptance until the result transaction completes; a stalled
// result holds. Reset is synchronous.
module uart_baud_divisor_search_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [23:0] req_baud_rate,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_divisor_word,
   output logic [7:0]  rsp_fractional_setting,
   output logic        rsp_fractional_valid,
   output logic        rsp_divide_error,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_PLAIN    = 8'b0000_0010,
      ST_RATE     = 8'b0000_0100,
      ST_FRAC     = 8'b0000_1000,
      ST_SYN_FOUT = 8'b0001_0000,
      ST_SYN_ACT  = 8'b0010_0000,
      ST_EVAL     = 8'b0100_0000,
      ST_DONE     = 8'b1000_0000
   } state_type;

   localparam logic [4:0] K_LAST   = 5'd16;
   localparam logic [3:0] MUL_LAST = 4'd15;

   state_type   state_ff, state_in;
   logic        go_ff, go_in;
   logic [31:0] cfg_clock_ff, cfg_clock_in;
   logic [1:0]  cfg_mode_ff, cfg_mode_in;
   logic [23:0] baud_ff, baud_in;
   logic [31:0] clk_ff, clk_in;
   logic [1:0]  mode_ff, mode_in;
   logic [31:0] word_ff, word_in;
   logic [31:0] rate_ff, rate_in;
   logic [3:0]  mul_ff, mul_in;
   logic [3:0]  add_ff, add_in;
   logic [4:0]  k_ff, k_in;
   logic [43:0] n_ff, n_in;
   logic [43:0] num_ff, num_in;
   logic [15:0] fout_ff, fout_in;
   logic [43:0] actual_ff, actual_in;
   logic [23:0] best_ff, best_in;
   logic [7:0]  frac_ff, frac_in;
   logic        fvalid_ff, fvalid_in;
   logic        derr_ff, derr_in;

   ubds_pkg::div_ctl_type div_ctl;
   ubds_pkg::div_sts_type div_sts;
   logic [ubds_pkg::DIV_W-1:0] div_dividend;
   logic [ubds_pkg::DVR_W-1:0] div_divisor;
   logic [ubds_pkg::DIV_W-1:0] div_quotient;
   logic [ubds_pkg::DVR_W-1:0] div_remainder;

   logic [43:0] baud_wide;
   logic [43:0] syn_num;
   logic [15:0] fin;
   logic [35:0] frac_prod;
   logic [43:0] err_up, err_dn, err;
   logic        better;
   logic [31:0] plain_val;
   logic        req_fire;

   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = state_ff == ST_DONE;
   assign csr_ready = 1'b1;
   assign req_fire  = req_valid && req_ready;

   assign baud_wide = {20'b0, baud_ff};
   assign syn_num   = ((baud_wide << k_ff) - baud_wide) << 4;
   assign fin       = 16'((17'd1 << k_ff) - 17'd1);
   assign frac_prod = {4'b0, rate_ff} * {32'b0, mul_ff};
   assign err_up    = actual_ff - baud_wide;
   assign err_dn    = baud_wide - actual_ff;
   assign err       = (actual_ff >= baud_wide) ? err_up : err_dn;
   assign better    = err < {20'b0, best_ff};

   always_comb begin
      div_ctl.start = go_ff;
      div_dividend  = {12'b0, clk_ff};
      div_divisor   = clk_ff;
      case (state_ff)
         ST_PLAIN: begin
            div_ctl.len = ubds_pkg::LEN_CLOCK;
            div_divisor = {4'b0, baud_ff, 4'b0};
         end
         ST_RATE: begin
            div_ctl.len = ubds_pkg::LEN_CLOCK;
            div_divisor = {word_ff[27:0], 4'b0};
         end
         ST_FRAC: begin
            div_ctl.len  = ubds_pkg::LEN_FRAC;
            div_dividend = {8'b0, frac_prod};
            div_divisor  = {27'b0, 5'({1'b0, mul_ff} + {1'b0, add_ff})};
         end
         ST_SYN_FOUT: begin
            div_ctl.len  = ubds_pkg::LEN_SYNTH;
            div_dividend = syn_num;
         end
         ST_SYN_ACT: begin
            div_ctl.len  = ubds_pkg::LEN_SYNTH;
            div_dividend = num_ff;
            div_divisor  = {12'b0, fin, 4'b0};
         end
         default: begin
            div_ctl.len = ubds_pkg::LEN_SYNTH;
         end
      endcase
   end

   ubds_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .ctl       (div_ctl),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .sts       (div_sts),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   always_comb begin
      state_in     = state_ff;
      cfg_clock_in = cfg_clock_ff;
      cfg_mode_in  = cfg_mode_ff;
      baud_in      = baud_ff;
      clk_in       = clk_ff;
      mode_in      = mode_ff;
      word_in      = word_ff;
      rate_in      = rate_ff;
      mul_in       = mul_ff;
      add_in       = add_ff;
      k_in         = k_ff;
      n_in         = n_ff;
      num_in       = num_ff;
      fout_in      = fout_ff;
      actual_in    = actual_ff;
      best_in      = best_ff;
      frac_in      = frac_ff;
      fvalid_in    = fvalid_ff;
      derr_in      = derr_ff;
      plain_val    = div_quotient[31:0];

      if (csr_valid && csr_ready) begin
         case (csr_index)
            ubds_pkg::CSR_CLOCK: cfg_clock_in = csr_data;
            ubds_pkg::CSR_MODE:  cfg_mode_in  = csr_data[1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               baud_in   = req_baud_rate;
               clk_in    = (cfg_clock_ff == 32'd0) ? ubds_pkg::FALLBACK_CLOCK : cfg_clock_ff;
               mode_in   = cfg_mode_ff;
               frac_in   = ubds_pkg::FRAC_DEFAULT;
               fvalid_in = 1'b0;
               derr_in   = 1'b0;
               best_in   = req_baud_rate;
               word_in   = '0;
               if (req_baud_rate != 24'd0) begin
                  state_in = ST_PLAIN;
               end else if (cfg_mode_ff == ubds_pkg::MODE_SYNTH) begin
                  word_in  = ubds_pkg::SYNTH_DEFAULT;
                  k_in     = 5'd1;
                  state_in = ST_SYN_FOUT;
               end else if (cfg_mode_ff == ubds_pkg::MODE_FRAC) begin
                  derr_in  = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_PLAIN: begin
            if (div_sts.done) begin
               word_in = plain_val;
               if (mode_ff == ubds_pkg::MODE_SYNTH) begin
                  word_in  = ubds_pkg::SYNTH_DEFAULT;
                  k_in     = 5'd1;
                  state_in = ST_SYN_FOUT;
               end else if (mode_ff == ubds_pkg::MODE_FRAC) begin
                  if (plain_val == 32'd0) begin
                     derr_in  = 1'b1;
                     state_in = ST_DONE;
                  end else begin
                     state_in = ST_RATE;
                  end
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_RATE: begin
            if (div_sts.done) begin
               rate_in  = div_quotient[31:0];
               mul_in   = 4'd1;
               add_in   = 4'd0;
               state_in = ST_FRAC;
            end
         end
         ST_FRAC: begin
            if (div_sts.done) begin
               actual_in = div_quotient;
               state_in  = ST_EVAL;
            end
         end
         ST_SYN_FOUT: begin
            if (go_ff) begin
               n_in = syn_num;
            end
            if (div_sts.done) begin
               fout_in  = div_quotient[15:0];
               num_in   = n_ff - {12'b0, div_remainder};
               state_in = ST_SYN_ACT;
            end
         end
         ST_SYN_ACT: begin
            if (div_sts.done) begin
               actual_in = div_quotient;
               state_in  = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (better) begin
               best_in = err[23:0];
            end
            if (mode_ff == ubds_pkg::MODE_SYNTH) begin
               if (better) begin
                  word_in = {fout_ff, fin};
               end
               if (k_ff == K_LAST) begin
                  state_in = ST_DONE;
               end else begin
                  k_in     = k_ff + 5'd1;
                  state_in = ST_SYN_FOUT;
               end
            end else begin
               if (better) begin
                  frac_in = {mul_ff, add_ff};
               end
               if (add_ff + 4'd1 != mul_ff) begin
                  add_in   = add_ff + 4'd1;
                  state_in = ST_FRAC;
               end else if (mul_ff == MUL_LAST) begin
                  fvalid_in = 1'b1;
                  state_in  = ST_DONE;
               end else begin
                  mul_in   = mul_ff + 4'd1;
                  add_in   = 4'd0;
                  state_in = ST_FRAC;
               end
            end
         end
         ST_DONE: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      go_in = (state_in != state_ff) &&
              (state_in == ST_PLAIN || state_in == ST_RATE || state_in == ST_FRAC ||
               state_in == ST_SYN_FOUT || state_in == ST_SYN_ACT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         go_ff        <= 1'b0;
         cfg_clock_ff <= ubds_pkg::RESET_CLOCK;
         cfg_mode_ff  <= ubds_pkg::MODE_PLAIN;
      end else begin
         state_ff     <= state_in;
         go_ff        <= go_in;
         cfg_clock_ff <= cfg_clock_in;
         cfg_mode_ff  <= cfg_mode_in;
      end
      baud_ff   <= baud_in;
      clk_ff    <= clk_in;
      mode_ff   <= mode_in;
      word_ff   <= word_in;
      rate_ff   <= rate_in;
      mul_ff    <= mul_in;
      add_ff    <= add_in;
      k_ff      <= k_in;
      n_ff      <= n_in;
      num_ff    <= num_in;
      fout_ff   <= fout_in;
      actual_ff <= actual_in;
      best_ff   <= best_in;
      frac_ff   <= frac_in;
      fvalid_ff <= fvalid_in;
      derr_ff   <= derr_in;
   end

   assign rsp_divisor_word       = word_ff;
   assign rsp_fractional_setting = frac_ff;
   assign rsp_fractional_valid   = fvalid_ff;
   assign rsp_divide_error       = derr_ff;

`ifndef SYNTHESIS
   a_start_when_free: assert property (@(posedge clock) disable iff (reset)
      div_ctl.start |-> !div_sts.busy)
      else $error("divider started while busy");

   a_no_accept_while_holding: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input ready while a result transaction is pending");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_fractional_valid && rsp_divide_error))
      else $error("fractional result and divide error both set");

   a_done_in_div_state: assert property (@(posedge clock) disable iff (reset)
      div_sts.done |-> (state_ff == ST_PLAIN || state_ff == ST_RATE || state_ff == ST_FRAC ||
                        state_ff == ST_SYN_FOUT || state_ff == ST_SYN_ACT))
      else $error("divider finished outside a division step");
`endif

endmodule

>>> design/ubds_divider.sv
module ubds_divider (
   input  logic                         clock,
   input  logic                         reset,
   input  ubds_pkg::div_ctl_type        ctl,
   input  logic [ubds_pkg::DIV_W-1:0]   dividend,
   input  logic [ubds_pkg::DVR_W-1:0]   divisor,
   output ubds_pkg::div_sts_type        sts,
   output logic [ubds_pkg::DIV_W-1:0]   quotient,
   output logic [ubds_pkg::DVR_W-1:0]   remainder
);

   localparam logic [ubds_pkg::LEN_W-1:0] FULL_LEN = ubds_pkg::LEN_W'(ubds_pkg::DIV_W);

   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [ubds_pkg::LEN_W-1:0]   count_ff, count_in;
   logic [ubds_pkg::DIV_W-1:0]   quo_ff, quo_in;
   logic [ubds_pkg::DVR_W-1:0]   rem_ff, rem_in;
   logic [ubds_pkg::DVR_W-1:0]   dvr_ff, dvr_in;

   logic [ubds_pkg::DVR_W:0]     shifted;
   logic [ubds_pkg::DVR_W:0]     trial;
   logic                         fits;

   assign shifted = {rem_ff, quo_ff[ubds_pkg::DIV_W-1]};
   assign trial   = shifted - {1'b0, dvr_ff};
   assign fits    = shifted >= {1'b0, dvr_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dvr_in   = dvr_ff;
      if (ctl.start) begin
         busy_in  = 1'b1;
         count_in = ctl.len;
         quo_in   = dividend << (FULL_LEN - ctl.len);
         rem_in   = '0;
         dvr_in   = divisor;
      end else if (busy_ff) begin
         quo_in   = {quo_ff[ubds_pkg::DIV_W-2:0], fits};
         rem_in   = fits ? trial[ubds_pkg::DVR_W-1:0] : shifted[ubds_pkg::DVR_W-1:0];
         count_in = count_ff - 1'b1;
         if (count_ff == ubds_pkg::LEN_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvr_ff <= dvr_in;
   end

   assign sts.busy  = busy_ff;
   assign sts.done  = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

>>> test/uart_baud_divisor_search_core_test.sv
`timescale 1ns / 100ps

module uart_baud_divisor_search_core_test;

   localparam logic [1:0]  MODE_ALIAS = 2'd3;
   localparam logic [31:0] CLK_RST    = ubds_pkg::RESET_CLOCK;
   localparam logic [7:0]  FRAC_DEF   = ubds_pkg::FRAC_DEFAULT;
   localparam int CYCLE_LIMIT = 4000000;
   localparam int DIRECTED_ROWS = 22;

   typedef struct packed {
      logic [31:0] word;
      logic [7:0]  frac;
      logic        fvalid;
      logic        derr;
   } divisor_set_type;

   typedef struct packed {
      logic [31:0]     clk_hz;
      logic [1:0]      mode;
      logic [23:0]     rate;
      logic            typed;
      divisor_set_type want;
   } rate_case_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [23:0] req_baud_rate;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_divisor_word;
   logic [7:0]  rsp_fractional_setting;
   logic        rsp_fractional_valid;
   logic        rsp_divide_error;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [31:0] csr_data;

   divisor_set_type settings_due [$];
   logic [31:0]  clock_hz_reg;
   logic [1:0]   mode_reg;
   int           mismatches;
   int           send_idle_pct;
   int           stall_pct;
   int           hold_request;
   int           cycle_count;

   int idle_plan [4] = '{0, 88, 0, 20};
   int stall_plan [4] = '{0, 0, 88, 20};

   rate_case_type directed_rows [DIRECTED_ROWS] = '{
      '{CLK_RST, ubds_pkg::MODE_PLAIN, 24'd115200, 1'b1, '{32'd26, FRAC_DEF, 1'b0, 1'b0}},
      '{CLK_RST, ubds_pkg::MODE_PLAIN, 24'd1, 1'b1, '{32'd3000000, FRAC_DEF, 1'b0, 1'b0}},
      '{CLK_RST, ubds_pkg::MODE_PLAIN, 24'hffffff, 1'b1, '{32'd0, FRAC_DEF, 1'b0, 1'b0}},
      '{CLK_RST, ubds_pkg::MODE_FRAC, 24'hffffff, 1'b1, '{32'd0, FRAC_DEF, 1'b0, 1'b1}},
      '{CLK_RST, ubds_pkg::MODE_FRAC, 24'd115200, 1'b0, '0},
      '{CLK_RST, ubds_pkg::MODE_FRAC, 24'd9600, 1'b0, '0},
      '{CLK_RST, ubds_pkg::MODE_FRAC, 24'd1, 1'b0, '0},
      '{CLK_RST, ubds_pkg::MODE_SYNTH, 24'd115200, 1'b0, '0},
      '{CLK_RST, ubds_pkg::MODE_SYNTH, 24'd1, 1'b0, '0},
      '{CLK_RST, ubds_pkg::MODE_SYNTH, 24'hffffff, 1'b0, '0},
      '{32'd0, ubds_pkg::MODE_PLAIN, 24'd1, 1'b1, '{32'd7200, FRAC_DEF, 1'b0, 1'b0}},
      '{32'd0, ubds_pkg::MODE_PLAIN, 24'hffffff, 1'b1, '{32'd0, FRAC_DEF, 1'b0, 1'b0}},
      '{32'd0, ubds_pkg::MODE_FRAC, 24'd7200, 1'b1, '{32'd1, FRAC_DEF, 1'b1, 1'b0}},
      '{32'd0, ubds_pkg::MODE_FRAC, 24'd7201, 1'b1, '{32'd0, FRAC_DEF, 1'b0, 1'b1}},
      '{32'd0, ubds_pkg::MODE_SYNTH, 24'hffffff, 1'b0, '0},
      '{32'hffffffff, ubds_pkg::MODE_PLAIN, 24'd1, 1'b1,
        '{32'h0fffffff, FRAC_DEF, 1'b0, 1'b0}},
      '{32'hffffffff, ubds_pkg::MODE_SYNTH, 24'd1, 1'b1,
        '{ubds_pkg::SYNTH_DEFAULT, FRAC_DEF, 1'b0, 1'b0}},
      '{32'hffffffff, ubds_pkg::MODE_FRAC, 24'hffffff, 1'b0, '0},
      '{32'hffffffff, ubds_pkg::MODE_FRAC, 24'd3, 1'b0, '0},
      '{CLK_RST, MODE_ALIAS, 24'd115200, 1'b1, '{32'd26, FRAC_DEF, 1'b0, 1'b0}},
      '{CLK_RST, MODE_ALIAS, 24'h800000, 1'b1, '{32'd0, FRAC_DEF, 1'b0, 1'b0}},
      '{32'd1843200, ubds_pkg::MODE_FRAC, 24'd115200, 1'b0, '0}
   };

   uart_baud_divisor_search_core uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_baud_rate(req_baud_rate),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_divisor_word(rsp_divisor_word),
      .rsp_fractional_setting(rsp_fractional_setting),
      .rsp_fractional_valid(rsp_fractional_valid),
      .rsp_divide_error(rsp_divide_error),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   function automatic longint unsigned effective_clock(logic [31:0] clk_reg);
      return (clk_reg == 32'd0) ? 64'(ubds_pkg::FALLBACK_CLOCK) : 64'(clk_reg);
   endfunction

   function automatic divisor_set_type predict_divisors(logic [23:0] rate,
                                                        logic [31:0] clk_reg,
                                                        logic [1:0] mode);
      divisor_set_type r;
      longint unsigned baud, clk, plain, best, fin, fout, actual, err, base;
      baud = 64'(rate);
      clk = effective_clock(clk_reg);
      plain = (baud != 64'd0) ? clk / (64'd16 * baud) : 64'd0;
      r.word = plain[31:0];
      r.frac = ubds_pkg::FRAC_DEFAULT;
      r.fvalid = 1'b0;
      r.derr = 1'b0;
      if (mode == ubds_pkg::MODE_SYNTH) begin
         best = baud;
         r.word = ubds_pkg::SYNTH_DEFAULT;
         for (int k = 1; k <= 16; k++) begin
            fin = (64'd1 << k) - 64'd1;
            fout = (baud * fin * 64'd16) / clk;
            actual = (clk * fout) / (64'd16 * fin);
            err = (actual > baud) ? actual - baud : baud - actual;
            if (err < best) begin
               best = err;
               r.word = {fout[15:0], fin[15:0]};
            end
         end
      end else if (mode == ubds_pkg::MODE_FRAC) begin
         if (plain == 64'd0) begin
            r.derr = 1'b1;
         end else begin
            base = clk / (64'd16 * plain);
            best = baud;
            for (longint unsigned m = 1; m < 16; m++) begin
               for (longint unsigned a = 0; a < m; a++) begin
                  actual = (m * base) / (m + a);
                  err = (actual > baud) ? actual - baud : baud - actual;
                  if (err < best) begin
                     best = err;
                     r.frac = {m[3:0], a[3:0]};
                  end
               end
            end
            r.fvalid = 1'b1;
         end
      end
      return r;
   endfunction

   function automatic logic [31:0] pick_clock();
      case ($urandom_range(5))
         0: return 32'd0;
         1: return 32'hffffffff;
         2: return ubds_pkg::RESET_CLOCK;
         3: return $urandom;
         4: return $urandom_range(1, 100000);
         default: return 32'd1843200;
      endcase
   endfunction

   function automatic logic [23:0] pick_rate(logic [31:0] clk_reg);
      longint unsigned clk, r;
      clk = effective_clock(clk_reg);
      case ($urandom_range(3))
         0: r = 64'($urandom_range(1, 24'hffffff));
         1: r = 64'(($urandom & 32'h00ffffff) >> $urandom_range(23));
         2: begin
            r = clk / (64'd16 * 64'($urandom_range(1, 64))) + 64'($urandom_range(2));
            r = (r > 64'd1) ? r - 64'd1 : 64'd1;
         end
         default: r = clk / (64'd16 * 64'($urandom_range(1, 4096)));
      endcase
      if (r == 64'd0) r = 64'd1;
      if (r > 64'hffffff) r = 64'hffffff;
      return r[23:0];
   endfunction

   task automatic report_mismatch(input string field, input longint unsigned got,
                                  input longint unsigned want);
      mismatches++;
      $display("MISMATCH %s: got 0x%0h, want 0x%0h", field, got, want);
   endtask

   task automatic offer_rate(input logic [23:0] rate, input logic typed,
                             input divisor_set_type want);
      req_valid <= 1'b1;
      req_baud_rate <= rate;
      do @(posedge clock); while (req_ready !== 1'b1);
      if (typed)
         settings_due.push_back(want);
      else
         settings_due.push_back(predict_divisors(rate, clock_hz_reg, mode_reg));
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (settings_due.size() != 0);
   endtask

   task automatic set_config(input logic [31:0] clk_val, input logic [1:0] mode_val);
      csr_valid <= 1'b1;
      csr_index <= ubds_pkg::CSR_CLOCK;
      csr_data <= clk_val;
      do @(posedge clock); while (csr_ready !== 1'b1);
      clock_hz_reg = clk_val;
      csr_index <= ubds_pkg::CSR_MODE;
      csr_data <= {30'd0, mode_val};
      do @(posedge clock); while (csr_ready !== 1'b1);
      mode_reg = mode_val;
      csr_valid <= 1'b0;
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      int hold_left;
      divisor_set_type due;
      hold_left = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
            if (settings_due.size() == 0) begin
               report_mismatch("result with none due", 64'(rsp_divisor_word), 64'd0);
            end else begin
               due = settings_due.pop_front();
               if (rsp_divisor_word !== due.word)
                  report_mismatch("divisor_word", 64'(rsp_divisor_word), 64'(due.word));
               if (rsp_fractional_setting !== due.frac)
                  report_mismatch("fractional_setting", 64'(rsp_fractional_setting),
                                  64'(due.frac));
               if (rsp_fractional_valid !== due.fvalid)
                  report_mismatch("fractional_valid", 64'(rsp_fractional_valid),
                                  64'(due.fvalid));
               if (rsp_divide_error !== due.derr)
                  report_mismatch("divide_error", 64'(rsp_divide_error), 64'(due.derr));
            end
         end
         if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   initial begin
      mismatches = 0;
      cycle_count = 0;
      hold_request = 0;
      send_idle_pct = 0;
      stall_pct = 0;
      clock_hz_reg = ubds_pkg::RESET_CLOCK;
      mode_reg = ubds_pkg::MODE_PLAIN;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_baud_rate <= 24'd0;
      csr_valid <= 1'b0;
      csr_index <= ubds_pkg::CSR_CLOCK;
      csr_data <= 32'd0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].clk_hz != clock_hz_reg || directed_rows[i].mode != mode_reg) begin
            drain_results();
            set_config(directed_rows[i].clk_hz, directed_rows[i].mode);
         end
         offer_rate(directed_rows[i].rate, directed_rows[i].typed, directed_rows[i].want);
      end

      for (int p = 0; p < 4; p++) begin
         send_idle_pct = idle_plan[p];
         stall_pct = stall_plan[p];
         for (int s = 0; s < 4; s++) begin
            drain_results();
            set_config(pick_clock(), 2'($urandom_range(3)));
            for (int n = 0; n < 8; n++)
               offer_rate(pick_rate(clock_hz_reg), 1'b0, '0);
         end
         if (p == 0) begin
            drain_results();
            set_config(ubds_pkg::RESET_CLOCK, ubds_pkg::MODE_PLAIN);
            hold_request = 3000;
            for (int n = 0; n < 4; n++)
               offer_rate(pick_rate(clock_hz_reg), 1'b0, '0);
         end
      end

      drain_results();
      repeat (50) @(posedge clock);
      if (mismatches == 0 && settings_due.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
